// ===== src/scfd_pkg.sv =====
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared types and constants for the STUN / ChannelData frame delimiter.
// ----------------------------------------------------------------------------
package scfd_pkg;

   // Widths of the stream and of the frame bookkeeping.
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 17;
   localparam int unsigned SIZE_W    = 16;
   localparam int unsigned HDR_W     = 48;
   localparam int unsigned COOKIE_W  = 32;

   // Protocol constants.
   localparam int unsigned CHANNEL_BIT_POS = 6;
   localparam logic [COOKIE_W-1:0] STUN_COOKIE = 32'h2112_A442;
   localparam logic [LEN_W-1:0] CHAN_HDR_LEN  = 17'd4;
   localparam logic [LEN_W-1:0] STUN_HDR_LEN  = 17'd20;
   localparam logic [LEN_W-1:0] COOKIE_END    = 17'd8;

   // Per-byte status reported with each echoed byte.
   typedef enum logic [1:0] {
      STATUS_ACCEPT = 2'd0,
      STATUS_FOUND  = 2'd1,
      STATUS_SKIP   = 2'd2
   } status_type;

   // Kind of the frame, once known.
   typedef enum logic {
      KIND_CHANNEL = 1'b0,
      KIND_STUN    = 1'b1
   } kind_type;

   // Payload of one result transaction.
   typedef struct packed {
      logic [BYTE_W-1:0] echo_byte;
      status_type        status;
      kind_type          frame_kind;
   } rsp_payload_type;

endpackage

// ===== src/scfd_channel_if.sv =====
// ----------------------------------------------------------------------------
// scfd channel interfaces
// Valid/ready channels for the incoming byte stream and the per-byte results.
// ----------------------------------------------------------------------------

// Incoming stream byte with its restart flag.
interface scfd_req_if import scfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

// Echoed byte with its framing status.
interface scfd_rsp_if import scfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] echo_byte;
   status_type        status;
   kind_type          frame_kind;

   modport source (output valid, output echo_byte, output status, output frame_kind,
                   input ready);
   modport sink   (input valid, input echo_byte, input status, input frame_kind,
                   output ready);
endinterface

// ===== src/stun_channel_frame_delimiter.sv =====
// ----------------------------------------------------------------------------
// stun_channel_frame_delimiter
// Finds the first STUN or ChannelData frame in a TCP byte stream and tags
// every byte with accepted, frame complete, or skipped.
// ----------------------------------------------------------------------------
//
//  Port     Direction  Transaction carries
//  req_ch   in         data_byte, restart
//  rsp_ch   out        echo_byte, status, frame_kind
//
// One byte is taken per clock while req_ch.ready is high; the framing state
// is updated in the cycle the byte is taken, and its result is registered
// in the output register, or in the skid register while that one is held.
// This two-entry output stage keeps input flowing while a result is stalled;
// req_ch.ready falls only when both entries are full.
// Reset is synchronous and active high; it returns the framer to idle.
//
module stun_channel_frame_delimiter
   import scfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   scfd_req_if.sink   req_ch,
   scfd_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_HEADER   = 3'd1,
      PH_COOKIE   = 3'd2,
      PH_DATA     = 3'd3,
      PH_FINISHED = 3'd4
   } phase_type;

   // Framing state.
   phase_type         phase_ff, phase_in, phase_cur;
   logic [HDR_W-1:0]  hdr_ff, hdr_in, hdr_cur, hdr_shift;
   logic [LEN_W-1:0]  cnt_ff, cnt_in, cnt_cur, cnt_inc;
   logic [LEN_W-1:0]  len_ff, len_in, len_cur;
   kind_type          kind_ff, kind_in, kind_cur;
   status_type        status_calc;

   // Output stage.
   logic              out_valid_ff, out_valid_in;
   rsp_payload_type   out_ff, out_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_payload_type   skid_ff, skid_in;
   rsp_payload_type   new_rsp;

   logic              accept;
   logic              out_fire;

   assign req_ch.ready = ~skid_valid_ff;
   assign accept       = req_ch.valid & req_ch.ready;
   assign out_fire     = out_valid_ff & rsp_ch.ready;

   // Framing decision for the byte on the input channel.
   always_comb begin
      if (req_ch.restart) begin
         phase_cur = PH_IDLE;
         hdr_cur   = '0;
         cnt_cur   = '0;
         len_cur   = '0;
         kind_cur  = KIND_CHANNEL;
      end else begin
         phase_cur = phase_ff;
         hdr_cur   = hdr_ff;
         cnt_cur   = cnt_ff;
         len_cur   = len_ff;
         kind_cur  = kind_ff;
      end

      hdr_shift   = {hdr_cur[HDR_W-BYTE_W-1:0], req_ch.data_byte};
      cnt_inc     = cnt_cur + LEN_W'(1);

      phase_in    = phase_cur;
      hdr_in      = hdr_cur;
      cnt_in      = cnt_cur;
      len_in      = len_cur;
      kind_in     = kind_cur;
      status_calc = STATUS_SKIP;

      unique case (phase_cur)
         PH_IDLE, PH_HEADER: begin
            phase_in    = PH_HEADER;
            hdr_in      = hdr_shift;
            cnt_in      = cnt_inc;
            status_calc = STATUS_ACCEPT;
            if (cnt_inc >= CHAN_HDR_LEN) begin
               // Bit 0x40 of the first header byte marks ChannelData.
               if (hdr_shift[3*BYTE_W+CHANNEL_BIT_POS]) begin
                  kind_in = KIND_CHANNEL;
                  len_in  = CHAN_HDR_LEN + LEN_W'(hdr_shift[SIZE_W-1:0]);
                  if (cnt_inc >= len_in) begin
                     status_calc = STATUS_FOUND;
                     phase_in    = PH_FINISHED;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end else begin
                  phase_in = PH_COOKIE;
               end
            end
         end
         PH_COOKIE: begin
            hdr_in      = hdr_shift;
            cnt_in      = cnt_inc;
            status_calc = STATUS_ACCEPT;
            if (cnt_inc >= COOKIE_END) begin
               if (hdr_shift[COOKIE_W-1:0] == STUN_COOKIE) begin
                  kind_in  = KIND_STUN;
                  len_in   = STUN_HDR_LEN
                           + LEN_W'(hdr_shift[COOKIE_W+SIZE_W-1:COOKIE_W]);
                  phase_in = PH_DATA;
               end else begin
                  status_calc = STATUS_SKIP;
                  phase_in    = PH_FINISHED;
               end
            end
         end
         PH_DATA: begin
            cnt_in = cnt_inc;
            if (cnt_inc >= len_cur) begin
               status_calc = STATUS_FOUND;
               phase_in    = PH_FINISHED;
            end else begin
               status_calc = STATUS_ACCEPT;
            end
         end
         default: begin
            status_calc = STATUS_SKIP;
         end
      endcase

      new_rsp.echo_byte  = req_ch.data_byte;
      new_rsp.status     = status_calc;
      new_rsp.frame_kind = kind_in;
   end

   // Output register and skid register steering.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_fire) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = accept;
            skid_in       = new_rsp;
         end else begin
            out_valid_in = accept;
            out_in       = new_rsp;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = new_rsp;
      end
   end

   // State and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hdr_ff        <= '0;
         cnt_ff        <= '0;
         len_ff        <= '0;
         kind_ff       <= KIND_CHANNEL;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            hdr_ff   <= hdr_in;
            cnt_ff   <= cnt_in;
            len_ff   <= len_in;
            kind_ff  <= kind_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.echo_byte  = out_ff.echo_byte;
   assign rsp_ch.status     = out_ff.status;
   assign rsp_ch.frame_kind = out_ff.frame_kind;

   // The skid register is only ever filled behind a held output register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output register is empty");

   // A completed frame always leaves the framer finished.
   assert property (@(posedge clock) disable iff (reset)
      (accept && status_calc == STATUS_FOUND) |=> (phase_ff == PH_FINISHED))
      else $error("frame completed without entering finished phase");

   // While payload bytes are counted, the count stays short of the frame length.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (cnt_ff < len_ff))
      else $error("byte count reached frame length in data phase");

   // Once finished, bytes are skipped until a restart.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !req_ch.restart && phase_ff == PH_FINISHED)
         |=> (phase_ff == PH_FINISHED))
      else $error("framer left finished phase without restart");

endmodule
